@@ design/tlq_pkg.sv @@
// Shared widths, register indexes and helper functions of the thick line quad expander.
package tlq_pkg;

  localparam int COORD_BITS = 20;
  localparam int DW = COORD_BITS + 1;       // endpoint difference
  localparam int AW = COORD_BITS;           // magnitude of a difference
  localparam int WW = 12;                   // thickness
  localparam int CLR_W = 32;                // packed colour
  localparam int SQ1W = 2 * AW;             // one square
  localparam int SQW = SQ1W + 1;            // sum of squares
  localparam int RADW = 2 * ((SQW + 20 + 1) / 2);  // radicand, even width
  localparam int LW = RADW / 2;             // length, integer square root
  localparam int PW = AW + WW;              // magnitude times thickness
  localparam int NUMW = PW + 11;            // rounded dividend
  localparam int DENW = LW + 1;             // twice the length
  localparam int QW = 12;                   // offset magnitude
  localparam int NW = QW + 1;               // signed offset
  localparam int SQC_W = $clog2(LW);
  localparam int DVC_W = $clog2(QW);
  localparam int VT_W = 17;
  localparam int IT_W = 18;
  localparam int IDX_W = 16;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERTICES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INDICES = 1'd1;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX = 1'b1;

  // Clamp a widened coordinate sum to the signed coordinate range.
  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [DW-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (v[DW-1] != v[DW-2]) begin
      r = v[DW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // Vertex offset within the quad for each of the six triangle indices.
  function automatic logic [1:0] tri_offset(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0: r = 2'd0;
      3'd1: r = 2'd1;
      3'd2: r = 2'd2;
      3'd3: r = 2'd0;
      3'd4: r = 2'd2;
      3'd5: r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/tlq_isqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
module tlq_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [tlq_pkg::RADW-1:0] radicand,
  output logic [tlq_pkg::LW-1:0]   root,
  output logic                     done
);
  import tlq_pkg::*;

  logic [RADW-1:0]  rad;
  logic [LW:0]      rem;
  logic [SQC_W-1:0] cnt;
  logic             busy;
  logic [LW+2:0]    rem_sh;
  logic [LW+2:0]    trial;
  logic             take;

  always_comb begin
    rem_sh = {rem, rad[RADW-1:RADW-2]};
    trial  = {1'b0, root, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= SQC_W'(LW - 1);
      end else if (busy) begin
        rad  <= {rad[RADW-3:0], 2'b00};
        rem  <= take ? (LW+1)'(rem_sh - trial) : rem_sh[LW:0];
        root <= {root[LW-2:0], take};
        cnt  <= cnt - SQC_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/tlq_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module tlq_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [tlq_pkg::NUMW-1:0] num,
  input  logic [tlq_pkg::DENW-1:0] den,
  output logic [tlq_pkg::QW-1:0]   quo,
  output logic                     done
);
  import tlq_pkg::*;

  logic [NUMW-1:0]  rem;
  logic [NUMW-1:0]  dsh;
  logic [DVC_W-1:0] cnt;
  logic             busy;
  logic             take;

  assign take = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= num;
        dsh  <= {den, {(QW-1){1'b0}}};
        quo  <= '0;
        cnt  <= DVC_W'(QW - 1);
      end else if (busy) begin
        if (take) begin
          rem <= rem - dsh;
        end
        dsh <= {1'b0, dsh[NUMW-1:1]};
        quo <= {quo[QW-2:0], take};
        cnt <= cnt - DVC_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/thick_line_quad_expander.sv @@
// Top level of the thick line quad expander: control, batch counters and result output.
//
// Channel   Direction  Handshake              Contents
// input     in         in_valid / in_ready    one segment: endpoints, thickness, colour
// output    out        out_valid / out_ready  one vertex or index per transaction
// config    in         cfg_we                 max_vertices (0), max_indices (1)
//
// A segment is taken only while the block is idle. It then forms the products,
// starts the square root, waits for the bit-serial square root (31 steps and the
// cycle that sees it done) and the two bit-serial dividers (12 steps and the done
// cycle), then emits its ten results; the square root takes most of that time.
// A new segment is taken only after the last result of the previous one is loaded.
// A zero-length segment is consumed at its handshake and produces nothing.
// Reset is synchronous and clears the control state, the batch counters and the
// registers to their defaults. A stalled output holds the block in the output phase.
module thick_line_quad_expander (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tlq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tlq_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] x_start,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] y_start,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] x_end,
  input  logic signed [tlq_pkg::COORD_BITS-1:0] y_end,
  input  logic [tlq_pkg::WW-1:0]               line_width,
  input  logic [tlq_pkg::CLR_W-1:0]            rgba_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 kind,
  output logic signed [tlq_pkg::COORD_BITS-1:0] vertex_x,
  output logic signed [tlq_pkg::COORD_BITS-1:0] vertex_y,
  output logic [tlq_pkg::CLR_W-1:0]            rgba_out,
  output logic [tlq_pkg::IDX_W-1:0]            index_value,
  output logic                                 flush_before,
  output logic                                 last
);
  import tlq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state;

  logic [VT_W-1:0] max_vertices;
  logic [IT_W-1:0] max_indices;
  logic [VT_W-1:0] vertex_total;
  logic [IT_W-1:0] index_total;

  // Captured segment.
  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  logic [WW-1:0]    wid;
  logic [CLR_W-1:0] rgba;

  // Products and signs of the direction.
  logic [SQ1W-1:0] sq_x, sq_y;
  logic [PW-1:0]   px, py;
  logic            dx_neg, dx_nz, dy_neg, dy_nz;

  // Offset, batch base and flush flag of the segment being emitted.
  logic signed [NW-1:0] nx, ny;
  logic [VT_W-1:0]      base;
  logic                 flush_pend;
  logic [3:0]           emit_cnt;

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        ax_full, ay_full;
  logic [AW-1:0]        ax, ay;
  logic                 zero_len;
  logic                 accept;

  logic             sqrt_start, sqrt_done;
  logic [LW-1:0]    root;
  logic             div_start, divx_done, divy_done;
  logic [QW-1:0]    magx, magy;
  logic [NUMW-1:0]  num_x, num_y;
  logic [DENW-1:0]  den;
  logic [SQW-1:0]   ssum;

  logic                 ovf;
  logic [VT_W-1:0]      base_next;
  logic [IT_W-1:0]      itot_base;
  logic signed [NW-1:0] nx_next, ny_next;
  logic signed [NW-1:0] magx_s, magy_s;

  logic                         load;
  logic signed [COORD_BITS-1:0] cx, cy;
  logic                         plus;
  logic signed [DW-1:0]         sum_x, sum_y;
  logic [2:0]                   tri_k;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign zero_len = (x_start == x_end) && (y_start == y_end);

  // Direction magnitudes; the magnitude of a difference always fits in AW bits.
  always_comb begin
    dx      = DW'(x2) - DW'(x1);
    dy      = DW'(y2) - DW'(y1);
    ax_full = dx[DW-1] ? DW'(-dx) : dx;
    ay_full = dy[DW-1] ? DW'(-dy) : dy;
    ax      = ax_full[AW-1:0];
    ay      = ay_full[AW-1:0];
  end

  // Square root of the squared length scaled by 2^20 gives the length in 1/1024 units.
  assign ssum       = SQW'(sq_x) + SQW'(sq_y);
  assign sqrt_start = (state == S_ADD);

  tlq_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (RADW'({ssum, 20'd0})),
    .root     (root),
    .done     (sqrt_done)
  );

  // Half-width offsets, rounded half up: (p * 1024 + L) / (2 * L).
  assign div_start = (state == S_SQRT) && sqrt_done;
  assign num_x     = NUMW'({px, 10'd0}) + NUMW'(root);
  assign num_y     = NUMW'({py, 10'd0}) + NUMW'(root);
  assign den       = {root, 1'b0};

  tlq_div u_div_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_x),
    .den   (den),
    .quo   (magx),
    .done  (divx_done)
  );

  tlq_div u_div_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_y),
    .den   (den),
    .quo   (magy),
    .done  (divy_done)
  );

  // The normal is (-dy, dx), so the x offset takes the opposite sign of dy.
  always_comb begin
    magx_s  = NW'(magx);
    magy_s  = NW'(magy);
    nx_next = !dy_nz ? '0 : (dy_neg ? magx_s : -magx_s);
    ny_next = !dx_nz ? '0 : (dx_neg ? -magy_s : magy_s);
    ovf = ((IT_W'(vertex_total) + IT_W'(4)) > IT_W'(max_vertices)) ||
          (((IT_W+1)'(index_total) + (IT_W+1)'(6)) > (IT_W+1)'(max_indices));
    base_next = ovf ? '0 : vertex_total;
    itot_base = ovf ? '0 : index_total;
  end

  // Output result selection: corners start+n, start-n, end-n, end+n, then indices.
  always_comb begin
    cx    = (emit_cnt < 4'd2) ? x1 : x2;
    cy    = (emit_cnt < 4'd2) ? y1 : y2;
    plus  = (emit_cnt == 4'd0) || (emit_cnt == 4'd3);
    sum_x = plus ? (DW'(cx) + DW'(nx)) : (DW'(cx) - DW'(nx));
    sum_y = plus ? (DW'(cy) + DW'(ny)) : (DW'(cy) - DW'(ny));
    tri_k = 3'(emit_cnt - 4'd4);
  end

  assign load = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_vertices <= VT_W'(65536);
      max_indices  <= IT_W'(98304);
      vertex_total <= '0;
      index_total  <= '0;
      out_valid    <= 1'b0;
      emit_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_VERTICES: max_vertices <= cfg_data[VT_W-1:0];
          CFG_MAX_INDICES:  max_indices  <= cfg_data[IT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept && !zero_len) begin
            state <= S_MUL;
          end
        end
        S_MUL:  state <= S_ADD;
        S_ADD:  state <= S_SQRT;
        S_SQRT: begin
          if (sqrt_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (divx_done && divy_done) begin
            state        <= S_EMIT;
            emit_cnt     <= '0;
            flush_pend   <= ovf && ((vertex_total != '0) || (index_total != '0));
            vertex_total <= base_next + VT_W'(4);
            index_total  <= itot_base + IT_W'(6);
          end
        end
        S_EMIT: begin
          if (load) begin
            out_valid <= 1'b1;
            emit_cnt  <= emit_cnt + 4'd1;
            if (emit_cnt == 4'd9) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      x1   <= x_start;
      y1   <= y_start;
      x2   <= x_end;
      y2   <= y_end;
      wid  <= line_width;
      rgba <= rgba_in;
    end
    if (state == S_MUL) begin
      sq_x   <= SQ1W'(ax) * SQ1W'(ax);
      sq_y   <= SQ1W'(ay) * SQ1W'(ay);
      px     <= PW'(ay) * PW'(wid);
      py     <= PW'(ax) * PW'(wid);
      dx_neg <= dx[DW-1];
      dy_neg <= dy[DW-1];
      dx_nz  <= (dx != '0);
      dy_nz  <= (dy != '0);
    end
    if ((state == S_DIV) && divx_done && divy_done) begin
      nx   <= nx_next;
      ny   <= ny_next;
      base <= base_next;
    end
    if (load) begin
      if (emit_cnt < 4'd4) begin
        kind         <= KIND_VERTEX;
        vertex_x     <= sat_coord(sum_x);
        vertex_y     <= sat_coord(sum_y);
        rgba_out     <= rgba;
        index_value  <= '0;
        flush_before <= (emit_cnt == 4'd0) && flush_pend;
        last         <= 1'b0;
      end else begin
        kind         <= KIND_INDEX;
        vertex_x     <= '0;
        vertex_y     <= '0;
        rgba_out     <= '0;
        index_value  <= base[IDX_W-1:0] + IDX_W'(tri_offset(tri_k));
        flush_before <= 1'b0;
        last         <= (emit_cnt == 4'd9);
      end
    end
  end

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (emit_cnt <= 4'd9))
    else $error("emit counter ran past the last result");

  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == S_SQRT))
    else $error("square root finished outside its phase");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    divx_done |-> ((state == S_DIV) && divy_done))
    else $error("dividers out of step");

  a_flush_first: assert property (@(posedge clk) disable iff (rst)
    (out_valid && flush_before) |-> ((kind == KIND_VERTEX) && !last))
    else $error("flush flag on a result other than the first");

  a_index_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_INDEX)) |-> ((vertex_x == '0) && (rgba_out == '0)))
    else $error("index result carries vertex data");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the thick line quad expander.
`timescale 1ns / 1ps

module testbench;
  import tlq_pkg::*;

  typedef struct {
    logic signed [COORD_BITS-1:0] xs;
    logic signed [COORD_BITS-1:0] ys;
    logic signed [COORD_BITS-1:0] xe;
    logic signed [COORD_BITS-1:0] ye;
    logic [WW-1:0]                w;
    logic [CLR_W-1:0]             rgba;
  } segment_t;

  typedef struct {
    logic                         kind;
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic [CLR_W-1:0]             rgba;
    logic [IDX_W-1:0]             idx;
    logic                         flush;
    logic                         last;
  } emit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_VERTICES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_BITS-1:0] x_start = '0, y_start = '0, x_end = '0, y_end = '0;
  logic [WW-1:0] line_width = '0;
  logic [CLR_W-1:0] rgba_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic signed [COORD_BITS-1:0] vertex_x, vertex_y;
  logic [CLR_W-1:0] rgba_out;
  logic [IDX_W-1:0] index_value;
  logic flush_before, last;

  thick_line_quad_expander dut (.*);

  always #5 clk = ~clk;

  // Stimulus waiting to be driven and the emits the predictor expects, oldest first.
  segment_t pending_segments[$];
  emit_t expected_emits[$];

  // Predictor copy of the capacity registers and the batch counters.
  int unsigned cap_vertices = 65536;
  int unsigned cap_indices = 98304;
  logic [VT_W-1:0] batch_vertices = '0;
  logic [IT_W-1:0] batch_indices = '0;

  int mismatches = 0;
  int emits_checked = 0;
  int segments_sent = 0;
  int ready_pct = 100;

  // Integer square root, one result bit per step.
  function automatic longint unsigned root_of(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[COORD_BITS-1:0];
  endfunction

  // Works out the ten emits of one accepted nonzero-length segment and advances the batch counters.
  task automatic predict_quad_emits(segment_t s);
    longint dx, dy, nx, ny;
    longint unsigned ax, ay, len, magx, magy;
    logic flush;
    logic [VT_W-1:0] base;
    emit_t e;
    int offs[6];
    longint cx[4], cy[4];
    offs = '{0, 1, 2, 0, 2, 3};
    dx = longint'(s.xe) - longint'(s.xs);
    dy = longint'(s.ye) - longint'(s.ys);
    // A segment of zero length is dropped without touching the batch.
    if (dx == 0 && dy == 0) return;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    while ((ax | ay) >= (64'd1 << 20)) begin
      ax >>= 1;
      ay >>= 1;
    end
    len = root_of((ax * ax + ay * ay) << 20);
    if (len == 0) len = 1;
    // The half-width offset is rounded half away from zero.
    magx = (ay * s.w * 1024 + len) / (2 * len);
    magy = (ax * s.w * 1024 + len) / (2 * len);
    nx = dy > 0 ? -longint'(magx) : (dy < 0 ? longint'(magx) : 0);
    ny = dx > 0 ? longint'(magy) : (dx < 0 ? -longint'(magy) : 0);
    flush = 1'b0;
    if (int'(batch_vertices) + 4 > cap_vertices || int'(batch_indices) + 6 > cap_indices) begin
      // The flush flag is only raised when the batch held something.
      flush = (batch_vertices != 0 || batch_indices != 0);
      batch_vertices = '0;
      batch_indices = '0;
    end
    base = batch_vertices;
    cx = '{s.xs + nx, s.xs - nx, s.xe - nx, s.xe + nx};
    cy = '{s.ys + ny, s.ys - ny, s.ye - ny, s.ye + ny};
    for (int k = 0; k < 4; k++) begin
      e.kind = KIND_VERTEX;
      e.vx = clamp_coord(cx[k]);
      e.vy = clamp_coord(cy[k]);
      e.rgba = s.rgba;
      e.idx = '0;
      e.flush = (k == 0) ? flush : 1'b0;
      e.last = 1'b0;
      expected_emits = {expected_emits, e};
    end
    for (int k = 0; k < 6; k++) begin
      e.kind = KIND_INDEX;
      e.vx = '0;
      e.vy = '0;
      e.rgba = '0;
      e.idx = IDX_W'(base + offs[k]);
      e.flush = 1'b0;
      e.last = (k == 5);
      expected_emits = {expected_emits, e};
    end
    batch_vertices = batch_vertices + VT_W'(4);
    batch_indices = batch_indices + IT_W'(6);
  endtask

  // Driver: sends pending segments in bursts of random length separated by random gaps.
  segment_t cur_seg;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_quad_emits(cur_seg);
        segments_sent++;
      end
      // The slot is free once nothing is held or the held transaction was just taken.
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_segments.size() > 0) begin
          cur_seg = pending_segments.pop_front();
          x_start <= cur_seg.xs;
          y_start <= cur_seg.ys;
          x_end <= cur_seg.xe;
          y_end <= cur_seg.ye;
          line_width <= cur_seg.w;
          rgba_in <= cur_seg.rgba;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the output at the rate of the current phase and checks every emit.
  always @(posedge clk) begin
    emit_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(1, 100) <= ready_pct);
      if (out_valid && out_ready) begin
        emits_checked++;
        if (expected_emits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected emit kind=%0d x=%0d y=%0d idx=%0d",
                     kind, vertex_x, vertex_y, index_value);
        end else begin
          e = expected_emits.pop_front();
          if (kind !== e.kind || vertex_x !== e.vx || vertex_y !== e.vy ||
              rgba_out !== e.rgba || index_value !== e.idx ||
              flush_before !== e.flush || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: emit mismatch at %0t", $realtime);
              $display("  expected kind=%0d x=%0d y=%0d rgba=%h idx=%0d flush=%0d last=%0d",
                       e.kind, e.vx, e.vy, e.rgba, e.idx, e.flush, e.last);
              $display("  actual   kind=%0d x=%0d y=%0d rgba=%h idx=%0d flush=%0d last=%0d",
                       kind, vertex_x, vertex_y, rgba_out, index_value, flush_before, last);
            end
          end
        end
      end
    end
  end

  function automatic segment_t make_seg(int xs, int ys, int xe, int ye, int w, logic [31:0] c);
    segment_t s;
    s.xs = COORD_BITS'(xs);
    s.ys = COORD_BITS'(ys);
    s.xe = COORD_BITS'(xe);
    s.ye = COORD_BITS'(ye);
    s.w = WW'(w);
    s.rgba = c;
    return s;
  endfunction

  // Random segment: mostly short strokes, some full-range, some at the edges or degenerate.
  function automatic segment_t random_segment();
    segment_t s;
    int mode;
    mode = $urandom_range(0, 9);
    s.xs = COORD_BITS'($urandom);
    s.ys = COORD_BITS'($urandom);
    s.rgba = $urandom;
    s.w = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                      : WW'($urandom);
    case (mode)
      0: begin
        s.xe = s.xs;
        s.ye = s.ys;
      end
      1, 2: begin
        s.xe = COORD_BITS'($urandom);
        s.ye = COORD_BITS'($urandom);
      end
      7: begin
        s.xs = $urandom_range(0, 1) ? COORD_BITS'(20'sh7FFFF - $urandom_range(0, 64))
                                    : COORD_BITS'(20'sh80000 + $urandom_range(0, 64));
        s.xe = s.xs;
        s.ye = COORD_BITS'(s.ys + $signed($urandom_range(0, 4000)) - 2000);
      end
      8, 9: begin
        s.xe = COORD_BITS'(s.xs + $signed($urandom_range(0, 6)) - 3);
        s.ye = COORD_BITS'(s.ys + $signed($urandom_range(0, 6)) - 3);
      end
      default: begin
        s.xe = COORD_BITS'(s.xs + $signed($urandom_range(0, 4000)) - 2000);
        s.ye = COORD_BITS'(s.ys + $signed($urandom_range(0, 4000)) - 2000);
      end
    endcase
    return s;
  endfunction

  // Appends one segment to the stimulus queue.
  task automatic queue_segment(segment_t s);
    pending_segments = {pending_segments, s};
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    if (idx == CFG_MAX_VERTICES) cap_vertices = value & 32'h1FFFF;
    else cap_indices = value & 32'h3FFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every segment went in and every emit came out, plus the block's tail.
  task automatic drain();
    while (pending_segments.size() != 0 || in_valid || expected_emits.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int caps_v[6];
    int caps_i[6];
    int pct[6];
    caps_v = '{65536, 4, 2, 131071, 12, 0};
    caps_i = '{98304, 6, 3, 262143, 40, 5};
    pct = '{100, 70, 40, 100, 85, 55};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed segments under the reset capacities: axis-aligned, diagonal, zero length,
    // extreme thickness, full-range endpoints, saturating corners and colour extremes.
    queue_segment(make_seg(0, 0, 160, 0, 32, 32'h11223344));
    queue_segment(make_seg(0, 0, 0, -160, 32, 32'h55667788));
    queue_segment(make_seg(100, 100, -300, -300, 48, 32'h0));
    queue_segment(make_seg(5, 5, 5, 5, 100, 32'hFFFFFFFF));
    queue_segment(make_seg(-20, 7, 900, -33, 0, 32'hFFFFFFFF));
    queue_segment(make_seg(-20, 7, 900, -33, 4095, 32'hA5A5A5A5));
    queue_segment(make_seg(-524288, -524288, 524287, 524287, 4095, 32'h5A5A5A5A));
    queue_segment(make_seg(524287, -524288, -524288, 524287, 4095, 32'h0));
    queue_segment(make_seg(524287, 524287, 524287, 524000, 4095, 32'hFFFFFFFF));
    queue_segment(make_seg(-524288, -524288, -524000, -524288, 4095, 32'h1));
    queue_segment(make_seg(0, 0, 1, 0, 4095, 32'h80000000));
    queue_segment(make_seg(0, 0, 0, 1, 4095, 32'h7FFFFFFF));
    queue_segment(make_seg(3, -3, 2, -2, 1, 32'hDEADBEEF));
    queue_segment(make_seg(-524288, 0, -524288, 0, 4095, 32'h0));
    queue_segment(make_seg(524287, 0, -524288, 0, 17, 32'hCAFEF00D));
    drain();

    // Random phases, each under its own capacities and output stall rate.
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_MAX_VERTICES, caps_v[p]);
      write_reg(CFG_MAX_INDICES, caps_i[p]);
      ready_pct = pct[p];
      for (int n = 0; n < 34; n++) queue_segment(random_segment());
      drain();
    end

    $display("Sent %0d segments and checked %0d emits over six capacity settings,",
             segments_sent, emits_checked);
    $display("including undersized batches, full-range registers and output stalls.");
    if (mismatches == 0 && expected_emits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d emits never seen", mismatches, expected_emits.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("ERROR: timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ thick_line_quad_expander.f @@
design/tlq_pkg.sv
design/tlq_isqrt.sv
design/tlq_div.sv
design/thick_line_quad_expander.sv
tb/testbench.sv
